@@ rtl/acr_pkg.sv @@
`default_nettype none

package acr_pkg;

   // radix codes of the two configuration registers
   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_HEX = 2'd1;
   localparam logic [1:0] BASE_BIN = 2'd2;
   localparam logic [1:0] BASE_RSV = 2'd3;

   // configuration register indexes
   localparam logic CSR_SOURCE_BASE = 1'b0;
   localparam logic CSR_TARGET_BASE = 1'b1;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;

   localparam logic [7:0] GLYPHS [0:15] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_PREP,
      ST_DABBLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
   } unit_status_type;

   typedef struct packed {
      logic load;
      logic wide;
      logic minus;
   } emit_ctrl_type;

   // the reserved code behaves as decimal
   function automatic logic [1:0] norm_base(input logic [1:0] b);
      return (b == BASE_RSV) ? BASE_DEC : b;
   endfunction

   function automatic logic [7:0] glyph(input logic [3:0] d);
      return GLYPHS[d];
   endfunction

endpackage

`default_nettype wire

@@ rtl/acr_accum.sv @@
`default_nettype none

module acr_accum #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic                  clear,
   input  wire logic [7:0]            in_char,
   input  wire logic [1:0]            source_base,
   output logic      [VALUE_BITS-1:0] value,
   output logic                       terminator
);

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic                  at_start_ff, at_start_in;

   logic [1:0]            sb;
   logic                  is_digit;
   logic [3:0]            dval;
   logic                  minus_take;
   logic [VALUE_BITS-1:0] acc_step;

   always_comb begin
      sb       = acr_pkg::norm_base(source_base);
      is_digit = 1'b0;
      dval     = in_char[3:0];
      if (sb == acr_pkg::BASE_BIN) begin
         is_digit = (in_char == acr_pkg::CHAR_ZERO) || (in_char == acr_pkg::CHAR_ONE);
      end else if (in_char inside {[acr_pkg::CHAR_ZERO:acr_pkg::CHAR_NINE]}) begin
         is_digit = 1'b1;
      end else if (sb == acr_pkg::BASE_HEX &&
                   (in_char inside {[acr_pkg::CHAR_UA:acr_pkg::CHAR_UF],
                                    [acr_pkg::CHAR_LA:acr_pkg::CHAR_LF]})) begin
         // low nibble of 'A'..'F' and 'a'..'f' is 1..6
         is_digit = 1'b1;
         dval     = in_char[3:0] + 4'd9;
      end
      minus_take = (sb == acr_pkg::BASE_DEC) && (in_char == acr_pkg::CHAR_MINUS) && at_start_ff;
      terminator = !is_digit && !minus_take;
   end

   always_comb begin
      case (sb)
         acr_pkg::BASE_HEX: acc_step = {acc_ff[VALUE_BITS-5:0], dval};
         acr_pkg::BASE_BIN: acc_step = {acc_ff[VALUE_BITS-2:0], dval[0]};
         default: acc_step = (acc_ff << 3) + (acc_ff << 1) + VALUE_BITS'(dval);
      endcase
   end

   always_comb begin
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      at_start_in = at_start_ff;
      if (clear) begin
         acc_in      = '0;
         neg_in      = 1'b0;
         at_start_in = 1'b1;
      end else if (take) begin
         if (is_digit) begin
            acc_in      = acc_step;
            at_start_in = 1'b0;
         end else if (minus_take) begin
            neg_in      = 1'b1;
            at_start_in = 1'b0;
         end else begin
            // terminator: fold the sign into the value
            acc_in = neg_ff ? (VALUE_BITS'(0) - acc_ff) : acc_ff;
            neg_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         at_start_ff <= 1'b1;
      end else begin
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         at_start_ff <= at_start_in;
      end
   end

   assign value = acc_ff;

endmodule

`default_nettype wire

@@ rtl/acr_dabble.sv @@
`default_nettype none

module acr_dabble #(
   parameter int VALUE_BITS = 32,
   parameter int DEC_DIGITS = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [VALUE_BITS-1:0]        mag,
   output logic      [4*DEC_DIGITS-1:0]      bcd,
   output acr_pkg::unit_status_type          status
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0]   bin_ff, bin_in;
   logic [4*DEC_DIGITS-1:0] bcd_ff, bcd_in;
   logic [4*DEC_DIGITS-1:0] bcd_adj;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;

   // add three to every digit of five or more before each shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? (bcd_ff[4*i +: 4] + 4'd3)
                                                       : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         bin_in  = mag;
         bcd_in  = '0;
         cnt_in  = CNT_BITS'(VALUE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {bcd_adj[4*DEC_DIGITS-2:0], bin_ff[VALUE_BITS-1]};
         bin_in  = bin_ff << 1;
         cnt_in  = cnt_ff - CNT_BITS'(1);
         busy_in = (cnt_ff != CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd         = bcd_ff;
   assign status.busy = busy_ff;

endmodule

`default_nettype wire

@@ rtl/acr_emit.sv @@
`default_nettype none

module acr_emit #(
   parameter int DIGIT_BITS = 40
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire acr_pkg::emit_ctrl_type               ctrl,
   input  wire logic [DIGIT_BITS-1:0]                digits,
   input  wire logic [$clog2(DIGIT_BITS+1)-1:0]      count,
   input  wire logic                                 rsp_tready,
   output logic                                      rsp_tvalid,
   output logic      [7:0]                           rsp_tdata,
   output logic                                      rsp_tlast,
   output acr_pkg::unit_status_type                  status
);

   localparam int CNT_BITS = $clog2(DIGIT_BITS + 1);

   logic [DIGIT_BITS-1:0] dig_ff, dig_in;
   logic [CNT_BITS-1:0]   left_ff, left_in;
   logic                  wide_ff, wide_in;
   logic                  lead_ff, lead_in;
   logic                  minus_ff, minus_in;
   logic                  busy_ff, busy_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic                  slot;
   logic [3:0]            cur;
   logic                  is_last;

   assign slot    = !valid_ff || rsp_tready;
   assign cur     = wide_ff ? dig_ff[DIGIT_BITS-1 -: 4] : {3'b000, dig_ff[DIGIT_BITS-1]};
   assign is_last = (left_ff == CNT_BITS'(1));

   always_comb begin
      dig_in   = dig_ff;
      left_in  = left_ff;
      wide_in  = wide_ff;
      lead_in  = lead_ff;
      minus_in = minus_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff && !rsp_tready;
      char_in  = char_ff;
      last_in  = last_ff;
      if (ctrl.load) begin
         dig_in   = digits;
         left_in  = count;
         wide_in  = ctrl.wide;
         minus_in = ctrl.minus;
         lead_in  = 1'b1;
         busy_in  = 1'b1;
      end else if (busy_ff && slot) begin
         if (minus_ff) begin
            minus_in = 1'b0;
            valid_in = 1'b1;
            char_in  = acr_pkg::CHAR_MINUS;
            last_in  = 1'b0;
         end else begin
            dig_in  = wide_ff ? (dig_ff << 4) : (dig_ff << 1);
            left_in = left_ff - CNT_BITS'(1);
            // leading zeros are dropped, but the final digit always goes out
            if (!(lead_ff && cur == 4'd0 && !is_last)) begin
               lead_in  = 1'b0;
               valid_in = 1'b1;
               char_in  = acr_pkg::glyph(cur);
               last_in  = is_last;
               busy_in  = !is_last;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         minus_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         minus_ff <= minus_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      left_ff <= left_in;
      wide_ff <= wide_in;
      lead_ff <= lead_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp_tdata   = char_ff;
   assign rsp_tlast   = last_ff;
   assign status.busy = busy_ff;

endmodule

`default_nettype wire

@@ rtl/ascii_radix_converter.sv @@
// ascii_radix_converter: reads a number as ascii text in one radix and writes it
// back as ascii text in another.
// req channel: one character per item in req_tdata, taken one per cycle while
//    a number is being read; decimal may start with a single '-'. any other
//    non-digit ends the number and is consumed without echo.
// rsp channel: the converted number, most significant character first, with
//    rsp_tlast on its final character. decimal output is signed; hex (upper
//    case) and binary output are the raw VALUE_BITS pattern without leading
//    zeros. a number with no digits gives "0".
// csr port: csr_index 0 selects the source radix, 1 the target radix
//    (0 decimal, 1 hex, 2 binary, 3 acts as decimal). write only while idle.
// timing: after the terminator the value first settles; decimal then runs the
//    shift-and-add-three conversion before the emitter is loaded. the emitter
//    walks one digit position per cycle unless a stalled rsp_tready holds it
//    (hex VALUE_BITS/4 rounded up, binary VALUE_BITS, decimal about
//    0.3*VALUE_BITS+1, plus one for a sign), leading zero positions included;
//    hex and binary results skip the bcd step. req_tready is low from the
//    terminator until the emitter is idle after its last character and the
//    state is back to reading; a stalled rsp_tready holds the emitter and so
//    the input. reset sets decimal in, hex out and empties the pipeline.

`default_nettype none

module ascii_radix_converter #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // tdata: in_char[7:0]
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   // tdata: out_char[7:0]
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,
   output logic            rsp_tlast,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [1:0] csr_wdata
);

   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int DEC_W      = 4 * DEC_DIGITS;
   localparam int HEX_W      = 4 * HEX_DIGITS;
   localparam int MAX_A      = (DEC_W > HEX_W) ? DEC_W : HEX_W;
   localparam int DIGIT_BITS = (MAX_A > VALUE_BITS) ? MAX_A : VALUE_BITS;
   localparam int CNT_BITS   = $clog2(DIGIT_BITS + 1);

   acr_pkg::state_type state_ff, state_in;

   logic [1:0] source_base_ff, target_base_ff;
   logic [1:0] tb;
   logic       minus_ff, minus_in;

   logic                      req_take;
   logic                      terminator;
   logic                      acc_clear;
   logic [VALUE_BITS-1:0]     value;
   logic [VALUE_BITS-1:0]     mag;
   logic                      dab_start;
   logic [DEC_W-1:0]          bcd;
   acr_pkg::unit_status_type  dab_stat;
   acr_pkg::unit_status_type  emit_stat;
   acr_pkg::emit_ctrl_type    emit_ctrl;
   logic [DIGIT_BITS-1:0]     emit_digits;
   logic [CNT_BITS-1:0]       emit_count;
   logic [HEX_W-1:0]          hex_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_base_ff <= acr_pkg::BASE_DEC;
         target_base_ff <= acr_pkg::BASE_HEX;
      end else if (csr_we) begin
         case (csr_index)
            acr_pkg::CSR_SOURCE_BASE: source_base_ff <= csr_wdata;
            acr_pkg::CSR_TARGET_BASE: target_base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign tb       = acr_pkg::norm_base(target_base_ff);
   assign req_take = req_tvalid && req_tready;
   assign mag      = value[VALUE_BITS-1] ? (VALUE_BITS'(0) - value) : value;
   assign hex_val  = HEX_W'(value);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acr_pkg::ST_ACCUM: begin
            if (req_take && terminator) state_in = acr_pkg::ST_PREP;
         end
         acr_pkg::ST_PREP: begin
            state_in = (tb == acr_pkg::BASE_DEC) ? acr_pkg::ST_DABBLE : acr_pkg::ST_EMIT;
         end
         acr_pkg::ST_DABBLE: begin
            if (!dab_stat.busy) state_in = acr_pkg::ST_EMIT;
         end
         acr_pkg::ST_EMIT: begin
            if (!emit_stat.busy) state_in = acr_pkg::ST_ACCUM;
         end
         default: state_in = acr_pkg::ST_ACCUM;
      endcase
   end

   // outputs
   always_comb begin
      req_tready     = 1'b0;
      acc_clear      = 1'b0;
      dab_start      = 1'b0;
      minus_in       = minus_ff;
      emit_ctrl      = '0;
      emit_ctrl.wide = (tb != acr_pkg::BASE_BIN);
      emit_digits    = DIGIT_BITS'(bcd) << (DIGIT_BITS - DEC_W);
      emit_count     = CNT_BITS'(DEC_DIGITS);
      case (state_ff)
         acr_pkg::ST_ACCUM: begin
            req_tready = 1'b1;
         end
         acr_pkg::ST_PREP: begin
            acc_clear = 1'b1;
            minus_in  = 1'b0;
            case (tb)
               acr_pkg::BASE_HEX: begin
                  emit_ctrl.load = 1'b1;
                  emit_digits    = DIGIT_BITS'(hex_val) << (DIGIT_BITS - HEX_W);
                  emit_count     = CNT_BITS'(HEX_DIGITS);
               end
               acr_pkg::BASE_BIN: begin
                  emit_ctrl.load = 1'b1;
                  emit_digits    = DIGIT_BITS'(value) << (DIGIT_BITS - VALUE_BITS);
                  emit_count     = CNT_BITS'(VALUE_BITS);
               end
               default: begin
                  dab_start = 1'b1;
                  minus_in  = value[VALUE_BITS-1];
               end
            endcase
         end
         acr_pkg::ST_DABBLE: begin
            emit_ctrl.load  = !dab_stat.busy;
            emit_ctrl.minus = minus_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acr_pkg::ST_ACCUM;
         minus_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         minus_ff <= minus_in;
      end
   end

   acr_accum #(
      .VALUE_BITS(VALUE_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .take       (req_take),
      .clear      (acc_clear),
      .in_char    (req_tdata),
      .source_base(source_base_ff),
      .value      (value),
      .terminator (terminator)
   );

   acr_dabble #(
      .VALUE_BITS(VALUE_BITS),
      .DEC_DIGITS(DEC_DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (dab_start),
      .mag   (mag),
      .bcd   (bcd),
      .status(dab_stat)
   );

   acr_emit #(
      .DIGIT_BITS(DIGIT_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (emit_ctrl),
      .digits    (emit_digits),
      .count     (emit_count),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .status    (emit_stat)
   );

   // no new characters while a number is being written out
   a_no_take_while_emit: assert property (@(posedge clock) disable iff (reset)
      emit_stat.busy |-> !req_tready)
      else $error("input accepted while emitter busy");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(dab_stat.busy && emit_stat.busy))
      else $error("bcd unit and emitter busy together");

   // a sign is never the whole number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata == acr_pkg::CHAR_MINUS) |-> !rsp_tlast)
      else $error("minus sign flagged as last character");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      emit_ctrl.load |-> !emit_stat.busy)
      else $error("emitter loaded while busy");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE      = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER  = 40;
   localparam int PHASE_ITEMS = 14;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } emitted_char_type;

   class radix_scoreboard;
      logic [1:0]       src_code;
      logic [1:0]       tgt_code;
      logic [31:0]      acc;
      bit               neg;
      bit               fresh;
      emitted_char_type expected_chars[$];
      int               errors;

      function new();
         src_code = acr_pkg::BASE_DEC;
         tgt_code = acr_pkg::BASE_HEX;
         acc      = '0;
         neg      = 1'b0;
         fresh    = 1'b1;
         errors   = 0;
      endfunction

      // code three acts as decimal
      static function logic [1:0] effective(logic [1:0] b);
         return (b == acr_pkg::BASE_RSV) ? acr_pkg::BASE_DEC : b;
      endfunction

      static function int digit_value(logic [1:0] b, logic [7:0] c);
         if (b == acr_pkg::BASE_BIN)
            return (c == acr_pkg::CHAR_ZERO || c == acr_pkg::CHAR_ONE) ?
                   int'(c - acr_pkg::CHAR_ZERO) : -1;
         if (c >= acr_pkg::CHAR_ZERO && c <= acr_pkg::CHAR_NINE)
            return int'(c - acr_pkg::CHAR_ZERO);
         if (b == acr_pkg::BASE_HEX) begin
            if (c >= acr_pkg::CHAR_LA && c <= acr_pkg::CHAR_LF)
               return int'(c - acr_pkg::CHAR_LA) + 10;
            if (c >= acr_pkg::CHAR_UA && c <= acr_pkg::CHAR_UF)
               return int'(c - acr_pkg::CHAR_UA) + 10;
         end
         return -1;
      endfunction

      function void write_reg(logic idx, logic [1:0] v);
         if (idx == acr_pkg::CSR_SOURCE_BASE)
            src_code = v;
         else
            tgt_code = v;
      endfunction

      function void note_char(logic [7:0] c);
         logic [1:0]  sb;
         logic [1:0]  tb_code;
         logic [31:0] value;
         logic [31:0] mag;
         logic [3:0]  d;
         logic [7:0]  line[$];
         logic [7:0]  rev[$];
         int          dv;
         sb = effective(src_code);
         tb_code = effective(tgt_code);
         dv = digit_value(sb, c);
         if (dv >= 0) begin
            case (sb)
               acr_pkg::BASE_HEX: acc = acc * 32'd16 + 32'(dv);
               acr_pkg::BASE_BIN: acc = acc * 32'd2 + 32'(dv);
               default:           acc = acc * 32'd10 + 32'(dv);
            endcase
            fresh = 1'b0;
            return;
         end
         if (sb == acr_pkg::BASE_DEC && c == acr_pkg::CHAR_MINUS && fresh) begin
            neg   = 1'b1;
            fresh = 1'b0;
            return;
         end
         value = neg ? -acc : acc;
         mag = value;
         if (tb_code == acr_pkg::BASE_DEC && value[31]) begin
            line.push_back(acr_pkg::CHAR_MINUS);
            mag = -value;
         end
         do begin
            case (tb_code)
               acr_pkg::BASE_HEX: begin d = mag[3:0];       mag = mag >> 4; end
               acr_pkg::BASE_BIN: begin d = {3'b0, mag[0]}; mag = mag >> 1; end
               default:           begin d = 4'(mag % 10);   mag = mag / 10; end
            endcase
            rev.push_back((d < 10) ? 8'(acr_pkg::CHAR_ZERO + d)
                                   : 8'(acr_pkg::CHAR_UA + d - 10));
         end while (mag != 0);
         for (int i = rev.size() - 1; i >= 0; i--)
            line.push_back(rev[i]);
         foreach (line[i])
            expected_chars.push_back('{line[i], i == line.size() - 1});
         acc   = '0;
         neg   = 1'b0;
         fresh = 1'b1;
      endfunction

      function void check_char(logic [7:0] ch, logic lst);
         emitted_char_type want;
         if (expected_chars.size() == 0) begin
            $display("%0t unexpected result: char %h last %b", $time, ch, lst);
            errors++;
            return;
         end
         want = expected_chars.pop_front();
         if (want.ch !== ch) begin
            $display("%0t out_char mismatch: expected %h, got %h", $time, want.ch, ch);
            errors++;
         end
         if (want.last !== lst) begin
            $display("%0t last mismatch: expected %b, got %b", $time, want.last, lst);
            errors++;
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [1:0] csr_wdata = '0;

   radix_scoreboard sb = new();
   bit              no_idle = 1'b0;
   int              sent_items = 0;
   int              idle_cycles = 0;

   ascii_radix_converter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 6);
   endfunction

   task automatic send_char(logic [7:0] c);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      sb.note_char(c);
      sent_items++;
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_char(s[i]);
   endtask

   // sender stops and waits until every converted char has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic send_number();
      logic [1:0] base;
      logic [7:0] c;
      int         ndig;
      int         maxdig;
      int         r;
      int         d;
      base = radix_scoreboard::effective(sb.src_code);
      maxdig = (base == acr_pkg::BASE_BIN) ? 34 : (base == acr_pkg::BASE_HEX) ? 10 : 12;
      if (base == acr_pkg::BASE_DEC && $urandom_range(0, 2) == 0)
         send_char(acr_pkg::CHAR_MINUS);
      r = $urandom_range(0, 9);
      ndig = (r == 0) ? 0 : (r <= 6) ? $urandom_range(1, 6) : $urandom_range(1, maxdig);
      repeat (ndig) begin
         case (base)
            acr_pkg::BASE_BIN: c = 8'(acr_pkg::CHAR_ZERO + $urandom_range(0, 1));
            acr_pkg::BASE_HEX: begin
               d = $urandom_range(0, 15);
               if (d < 10)
                  c = 8'(acr_pkg::CHAR_ZERO + d);
               else if ($urandom_range(0, 1) == 0)
                  c = 8'(acr_pkg::CHAR_LA + d - 10);
               else
                  c = 8'(acr_pkg::CHAR_UA + d - 10);
            end
            default: c = 8'(acr_pkg::CHAR_ZERO + $urandom_range(0, 9));
         endcase
         send_char(c);
      end
      do c = 8'($urandom_range(0, 255)); while (radix_scoreboard::digit_value(base, c) >= 0);
      send_char(c);
   endtask

   // result side: random backpressure plus one long hold-off
   initial begin
      int got;
      int gap;
      got = 0;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_char(rsp_tdata, rsp_tlast);
         got++;
         if (got == HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int         phase_start;
      logic [1:0] src;
      logic [1:0] tgt;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset radices: decimal in, hex out
      send_text("-1 ");
      send_text("  ");
      send_text("-;");
      send_text("--");
      send_text("5-");
      drain();
      write_csr(acr_pkg::CSR_SOURCE_BASE, acr_pkg::BASE_HEX);
      write_csr(acr_pkg::CSR_TARGET_BASE, acr_pkg::BASE_DEC);
      send_text("80000000 ");
      send_text("aF/");
      send_text("-");
      drain();
      write_csr(acr_pkg::CSR_SOURCE_BASE, acr_pkg::BASE_RSV);
      write_csr(acr_pkg::CSR_TARGET_BASE, acr_pkg::BASE_BIN);
      send_text("12g");

      for (int p = 0; p < 7; p++) begin
         drain();
         case (p)
            0:       begin src = acr_pkg::BASE_DEC; tgt = acr_pkg::BASE_BIN; end
            1:       begin src = acr_pkg::BASE_BIN; tgt = acr_pkg::BASE_DEC; end
            2:       begin src = acr_pkg::BASE_HEX; tgt = acr_pkg::BASE_HEX; end
            3:       begin src = acr_pkg::BASE_RSV; tgt = acr_pkg::BASE_RSV; end
            default: begin src = 2'($urandom_range(0, 3)); tgt = 2'($urandom_range(0, 3)); end
         endcase
         write_csr(acr_pkg::CSR_SOURCE_BASE, src);
         write_csr(acr_pkg::CSR_TARGET_BASE, tgt);
         no_idle = (p == 2) || ($urandom_range(0, 3) == 0);
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
            else
               send_number();
         end
         // close any number left open by noise
         send_char(8'h20);
      end
      no_idle = 1'b0;
      drain();

      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

@@ ascii_radix_converter.f @@
rtl/acr_pkg.sv
rtl/acr_accum.sv
rtl/acr_dabble.sv
rtl/acr_emit.sv
rtl/ascii_radix_converter.sv
tb/tb.sv
